[hw/rtl/u8m_pkg.sv]
// ============================================================================
// u8m_pkg
// Shared widths, types and defaults for the UTF-8 to modified UTF-8 encoder.
// ============================================================================
package u8m_pkg;

    // Byte lanes on both streams
    localparam int BYTE_W = 8;

    // Assembled code point width (four-byte lead gives 3 + 3 * 6 bits)
    localparam int CODE_W = 21;

    // Default depth of the code point queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

[hw/rtl/utf8_to_modified_utf8_encoder_core.sv]
// ============================================================================
// utf8_to_modified_utf8_encoder_core
// Converts standard UTF-8 to modified UTF-8 (zero as C0 80, supplementary
// characters as two three-byte surrogates).
// ============================================================================
//  channel   dir  tdata            tuser         tlast
//  s_axis    in   in_byte[7:0]     frame_start   -
//  m_axis    out  out_byte[7:0]    -             run_last
//
//  One input byte per cycle while the code point queue has room; a completed
//  character leaves as 1, 2, 3 or 6 bytes at one byte per cycle while
//  m_tready allows, set by the single output register of the back end.
//  Completed code points pass the queue, code register and output register.
//  rst_n clears sequence state, queue and output valid asynchronously.
//  Output stalls fill the queue; input then stalls when the queue is full.
// ============================================================================
module utf8_to_modified_utf8_encoder_core
#(
    parameter int QUEUE_DEPTH = u8m_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // run_last
);

    u8m_pkg::q_status_t q_status;
    logic               push;
    u8m_pkg::code_t     push_code;
    logic               pop;
    u8m_pkg::code_t     head_code;

    u8m_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .frame_start (s_tuser),
        .q_status    (q_status),
        .push        (push),
        .push_code   (push_code)
    );

    u8m_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_code (push_code),
        .pop       (pop),
        .head_code (head_code),
        .status    (q_status)
    );

    u8m_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_code (head_code),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .run_last  (m_tlast)
    );

endmodule

[hw/rtl/u8m_front.sv]
// ============================================================================
// u8m_front
// Input side: accepts raw UTF-8 bytes, tracks the sequence and pushes each
// completed code point into the queue.
// ============================================================================
module u8m_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  u8m_pkg::byte_t        in_byte,
    input  logic                  frame_start,
    input  u8m_pkg::q_status_t    q_status,
    output logic                  push,
    output u8m_pkg::code_t        push_code
);

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    u8m_pkg::code_t  accum_reg;
    u8m_pkg::code_t  accum_next;
    logic [1:0]      pend_eff;
    logic            take;

    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready;

    // Sequence decode
    always_comb
    begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        push         = 1'b0;
        push_code    = accum_reg;
        pend_eff     = frame_start ? 2'd0 : pending_reg;
        if (take)
        begin
            if (pend_eff == 2'd0)
            begin
                if (in_byte[7] == 1'b0)
                begin
                    // Single-byte character
                    accum_next   = {{(u8m_pkg::CODE_W-8){1'b0}}, in_byte};
                    pending_next = 2'd0;
                    push         = 1'b1;
                    push_code    = accum_next;
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    accum_next   = {{(u8m_pkg::CODE_W-5){1'b0}}, in_byte[4:0]};
                    pending_next = 2'd1;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    accum_next   = {{(u8m_pkg::CODE_W-4){1'b0}}, in_byte[3:0]};
                    pending_next = 2'd2;
                end
                else
                begin
                    // Any other lead opens a four-byte sequence
                    accum_next   = {{(u8m_pkg::CODE_W-3){1'b0}}, in_byte[2:0]};
                    pending_next = 2'd3;
                end
            end
            else
            begin
                // Continuation: low six bits only, top bits unchecked
                accum_next   = {accum_reg[u8m_pkg::CODE_W-7:0], in_byte[5:0]};
                pending_next = pend_eff - 2'd1;
                if (pend_eff == 2'd1)
                begin
                    push      = 1'b1;
                    push_code = accum_next;
                end
            end
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            accum_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

[hw/rtl/u8m_queue.sv]
// ============================================================================
// u8m_queue
// Small FIFO of completed code points between the front and the back.
// ============================================================================
module u8m_queue
#(
    parameter int DEPTH = u8m_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8m_pkg::code_t        push_code,
    input  logic                  pop,
    output u8m_pkg::code_t        head_code,
    output u8m_pkg::q_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8m_pkg::code_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full      = (count_reg == CNT_FULL);
    assign status.not_empty = (count_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign head_code        = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_code;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/u8m_back.sv]
// ============================================================================
// u8m_back
// Output side: takes one code point at a time from the queue and sends its
// modified UTF-8 bytes, one per cycle unless stalled, via an output register.
// ============================================================================
module u8m_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8m_pkg::q_status_t    q_status,
    input  u8m_pkg::code_t        head_code,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8m_pkg::byte_t        out_byte,
    output logic                  run_last
);

    localparam u8m_pkg::code_t SUPP_BASE = u8m_pkg::CODE_W'(32'h10000);
    localparam logic [15:0]    HI_SURR   = 16'hD800;
    localparam logic [15:0]    LO_SURR   = 16'hDC00;

    // Number of output bytes for a code point
    function automatic logic [2:0] enc_len(input u8m_pkg::code_t code);
        logic [2:0] n;
        if (code == '0)
            n = 3'd2;
        else if (code <= u8m_pkg::CODE_W'(32'h7F))
            n = 3'd1;
        else if (code <= u8m_pkg::CODE_W'(32'h7FF))
            n = 3'd2;
        else if (code <= u8m_pkg::CODE_W'(32'hFFFF))
            n = 3'd3;
        else
            n = 3'd6;
        return n;
    endfunction

    // One byte of the three-byte form of a 16-bit unit
    function automatic u8m_pkg::byte_t enc_three(input logic [15:0] unit,
                                                 input logic [1:0] k);
        u8m_pkg::byte_t b;
        case (k)
            2'd0:    b = {4'hE, unit[15:12]};
            2'd1:    b = {2'b10, unit[11:6]};
            default: b = {2'b10, unit[5:0]};
        endcase
        return b;
    endfunction

    // Byte at position idx of the encoding
    function automatic u8m_pkg::byte_t enc_byte(input u8m_pkg::code_t code,
                                                input logic [2:0] idx);
        u8m_pkg::code_t cp;
        logic [15:0]    hi;
        logic [15:0]    lo;
        logic [2:0]     k;
        u8m_pkg::byte_t b;
        cp = code - SUPP_BASE;
        hi = HI_SURR | {5'd0, cp[20:10]};
        lo = LO_SURR | {6'd0, cp[9:0]};
        k  = idx - 3'd3;
        if (code == '0)
            b = (idx == 3'd0) ? 8'hC0 : 8'h80;
        else if (code <= u8m_pkg::CODE_W'(32'h7F))
            b = {1'b0, code[6:0]};
        else if (code <= u8m_pkg::CODE_W'(32'h7FF))
            b = (idx == 3'd0) ? {3'b110, code[10:6]} : {2'b10, code[5:0]};
        else if (code <= u8m_pkg::CODE_W'(32'hFFFF))
            b = enc_three(code[15:0], idx[1:0]);
        else if (idx < 3'd3)
            b = enc_three(hi, idx[1:0]);
        else
            b = enc_three(lo, k[1:0]);
        return b;
    endfunction

    logic            cur_valid_reg;
    u8m_pkg::code_t  cur_code_reg;
    logic [2:0]      idx_reg;
    logic            out_valid_reg;
    u8m_pkg::byte_t  out_byte_reg;
    logic            out_last_reg;
    logic            out_free;
    logic            move;
    logic            at_end;
    logic            last_move;

    assign out_free  = !out_valid_reg || out_ready;
    assign move      = cur_valid_reg && out_free;
    assign at_end    = (idx_reg == enc_len(cur_code_reg) - 3'd1);
    assign last_move = move && at_end;
    assign pop       = q_status.not_empty && (!cur_valid_reg || last_move);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_last_reg;

    // Current code point and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (last_move)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_code_reg <= head_code;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg <= enc_byte(cur_code_reg, idx_reg);
            out_last_reg <= at_end;
        end
    end

endmodule

[tb/tb_utf8_to_modified_utf8_encoder_core.sv]
// ============================================================================
// tb_utf8_to_modified_utf8_encoder_core
// Feeds standard UTF-8 bytes into the encoder and checks each modified UTF-8
// output item against a byte-level decoder/encoder kept in the bench. A short
// directed run covers the edge cases, then random character streams run with
// three input/output idle mixes and one long output hold-off.
// ============================================================================
module tb_utf8_to_modified_utf8_encoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 128;   // per idle mix
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        u8m_pkg::byte_t in_byte;
        logic           frame_start;
    } in_item_t;

    typedef struct packed {
        u8m_pkg::byte_t out_byte;
        logic           run_last;
    } out_item_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Bytes waiting to be offered, and output items still owed by the block
    in_item_t  byte_feed [$];
    out_item_t expected_mutf8 [$];

    // Bench copy of the decoder state
    logic [1:0]     seq_left = '0;
    u8m_pkg::code_t code_acc = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    logic hold_armed = 1'b0;
    logic hold_done  = 1'b0;

    utf8_to_modified_utf8_encoder_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .s_tuser  (s_tuser),   // [0] frame_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tlast  (m_tlast)    // run_last
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Decode one accepted byte; on a completed character queue its output
    function automatic void convert_byte(u8m_pkg::byte_t c, logic start);
        u8m_pkg::byte_t run_bytes [6];
        logic [15:0]    units [2];
        int             n_run;
        int             n_units;
        logic           done;
        u8m_pkg::code_t cp;
        out_item_t      item;
        n_run   = 0;
        n_units = 0;
        done    = 1'b0;
        if (start)
            seq_left = '0;
        if (seq_left == 0)
        begin
            if (c <= 8'h7F)
            begin
                code_acc = u8m_pkg::code_t'(c);
                done     = 1'b1;
            end
            else if ((c & 8'hE0) == 8'hC0)
            begin
                code_acc = u8m_pkg::code_t'(c & 8'h1F);
                seq_left = 2'd1;
            end
            else if ((c & 8'hF0) == 8'hE0)
            begin
                code_acc = u8m_pkg::code_t'(c & 8'h0F);
                seq_left = 2'd2;
            end
            else
            begin
                code_acc = u8m_pkg::code_t'(c & 8'h07);
                seq_left = 2'd3;
            end
        end
        else
        begin
            code_acc = {code_acc[u8m_pkg::CODE_W-7:0], c[5:0]};
            seq_left = seq_left - 2'd1;
            done     = (seq_left == 0);
        end
        if (done)
        begin
            if (code_acc == 0)
            begin
                run_bytes[0] = 8'hC0;
                run_bytes[1] = 8'h80;
                n_run = 2;
            end
            else if (code_acc <= 21'h7F)
            begin
                run_bytes[0] = code_acc[7:0];
                n_run = 1;
            end
            else if (code_acc <= 21'h7FF)
            begin
                run_bytes[0] = 8'hC0 | {3'b000, code_acc[10:6]};
                run_bytes[1] = 8'h80 | {2'b00, code_acc[5:0]};
                n_run = 2;
            end
            else if (code_acc <= 21'hFFFF)
            begin
                units[0] = code_acc[15:0];
                n_units  = 1;
            end
            else
            begin
                // Supplementary: high and low surrogate, extra high bits ORed in
                cp       = code_acc - 21'h10000;
                units[0] = 16'hD800 | 16'(cp >> 10);
                units[1] = 16'hDC00 | {6'b0, cp[9:0]};
                n_units  = 2;
            end
            for (int u = 0; u < n_units; u++)
            begin
                run_bytes[n_run]     = 8'hE0 | {4'b0000, units[u][15:12]};
                run_bytes[n_run + 1] = 8'h80 | {2'b00, units[u][11:6]};
                run_bytes[n_run + 2] = 8'h80 | {2'b00, units[u][5:0]};
                n_run += 3;
            end
            for (int i = 0; i < n_run; i++)
            begin
                item.out_byte = run_bytes[i];
                item.run_last = (i == n_run - 1);
                expected_mutf8 = {expected_mutf8, item};
            end
        end
    endfunction

    task automatic add_item(u8m_pkg::byte_t b, logic start);
        in_item_t item;
        item.in_byte     = b;
        item.frame_start = start;
        byte_feed = {byte_feed, item};
    endtask

    // Queue a UTF-8 sequence of len bytes for code, keeping only the first keep
    task automatic add_seq(logic [20:0] code, int len, logic start, int keep);
        u8m_pkg::byte_t b;
        logic [1:0]     top;
        case (len)
            1:       b = code[7:0];
            2:       b = 8'hC0 | {3'b000, code[10:6]};
            3:       b = 8'hE0 | {4'b0000, code[15:12]};
            default: b = 8'hF0 | {5'b00000, code[20:18]};
        endcase
        add_item(b, start);
        for (int i = len - 2; i >= 0 && (len - 1 - i) < keep; i--)
        begin
            // continuation marker bits are ignored, so scramble them now and then
            top = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'b10;
            add_item({top, code[6*i +: 6]}, 1'b0);
        end
    endtask

    task automatic add_directed();
        add_item(8'h00, 1'b1);                 // zero as C0 80
        add_item(8'h7F, 1'b0);
        add_item(8'hC0, 1'b0);                 // overlong zero
        add_item(8'h80, 1'b0);
        add_item(8'hDF, 1'b0);                 // 0x7FF
        add_item(8'hBF, 1'b0);
        add_seq(21'h00FFFF, 3, 1'b0, 3);
        add_seq(21'h010000, 4, 1'b0, 4);
        add_seq(21'h10FFFF, 4, 1'b0, 4);
        add_item(8'hFF, 1'b0);                 // high lead, above 0x10FFFF
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'h80, 1'b0);                 // stray byte opens four-byte run
        add_item(8'hC0, 1'b0);                 // lead bytes in continuation slot
        add_item(8'hFF, 1'b0);
        add_item(8'h81, 1'b0);
        add_item(8'hE2, 1'b0);                 // unfinished, then dropped
        add_item(8'h82, 1'b0);
        add_item(8'h41, 1'b1);
    endtask

    // Mostly well-formed characters, some overlong, broken or noise bytes
    task automatic add_random(int count);
        int          target;
        int          pick;
        int          len;
        logic [20:0] code;
        logic        start;
        logic        restart;
        restart = 1'b0;
        target  = byte_feed.size() + count;
        while (byte_feed.size() < target)
        begin
            pick  = $urandom_range(99);
            start = restart || ($urandom_range(19) == 0);
            restart = 1'b0;
            if (pick < 70)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       code = 21'($urandom_range(8'h7F));
                    2:       code = 21'($urandom_range(11'h7FF, 8'h80));
                    3:       code = 21'($urandom_range(16'hFFFF, 12'h800));
                    default: code = ($urandom_range(3) != 0) ?
                                    21'($urandom_range(21'h10FFFF, 21'h10000)) :
                                    21'($urandom_range(21'h1FFFFF, 21'h110000));
                endcase
                add_seq(code, len, start, len);
            end
            else if (pick < 80)
            begin
                len  = $urandom_range(2, 4);
                code = 21'($urandom_range(8'h7F));
                add_seq(code, len, start, len);
            end
            else if (pick < 88)
            begin
                len  = $urandom_range(2, 4);
                code = 21'($urandom());
                add_seq(code, len, start, $urandom_range(1, len - 1));
                restart = 1'b1;
            end
            else
            begin
                add_item(u8m_pkg::byte_t'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
    endtask

    // Input side: offer queued bytes, predict on every accepted one
    always @(posedge clk or negedge rst_n)
    begin : feed_driver
        logic     slot_free;
        in_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            slot_free = !s_tvalid;
            if (s_tvalid && s_tready)
            begin
                convert_byte(s_tdata, s_tuser);
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.in_byte;
                    s_tuser  <= nxt.frame_start;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: compare each accepted item with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : out_monitor
        out_item_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_mutf8.size() == 0)
                begin
                    $error("unexpected output item: out_byte %02h run_last %0b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_mutf8.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.run_last)
                    begin
                        $error("run_last mismatch: expected %0b, actual %0b",
                               want.run_last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long output hold-off so the queue fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin : rx_hold
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[utf8_to_modified_utf8_encoder_core] ERROR");
            $finish;
        end
    end

    // Reset, then three idle mixes, then drain and report
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        for (int mix = 0; mix < 3; mix++)
        begin
            @(negedge clk);
            case (mix)
                0:
                begin
                    tx_idle_pct = 24;
                    rx_idle_pct = 54;
                    add_directed();
                end
                1:
                begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 24;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_armed  = 1'b1;
                end
            endcase
            add_random(RANDOM_ITEMS);
            while (byte_feed.size() != 0 || s_tvalid || expected_mutf8.size() != 0)
                @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[utf8_to_modified_utf8_encoder_core] OK");
        else
            $display("[utf8_to_modified_utf8_encoder_core] ERROR");
        $finish;
    end

endmodule
